// ----- design/rhc_pkg.sv -----
// Shared types and constants for the RGB/HSV hexcone color converter.
package rhc_pkg;

  // Width of every color component port
  localparam int FW = 13;

  typedef logic [FW-1:0] field_t;

  // Control and payload that travels beside the divider lanes
  typedef struct packed {
    logic   valid;     // beat occupies this stage
    logic   hsv;       // 1: HSV to RGB, result already final in c0..c2
    logic   sat_zero;  // RGB to HSV: max is zero, saturation forced to zero
    logic   hue_zero;  // RGB to HSV: max equals min, hue forced to zero
    field_t c0;        // red (HSV to RGB)
    field_t c1;        // green (HSV to RGB)
    field_t c2;        // blue (HSV to RGB) or value (RGB to HSV)
  } side_t;

endpackage

// ----- design/rhc_front.sv -----
// Front pipeline: input clamp, min/max and hue numerator, HSV products, first divide step.
module rhc_front
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  input  field_t               in_first,
  input  field_t               in_second,
  input  field_t               in_third,
  output side_t                side_o,
  output logic [FRAC_BITS+3:0] rem_s_o,
  output logic [FRAC_BITS+3:0] dvs_s_o,
  output logic [FRAC_BITS:0]   quo_s_o,
  output logic [FRAC_BITS+3:0] rem_h_o,
  output logic [FRAC_BITS+3:0] dvs_h_o,
  output logic [FRAC_BITS:0]   quo_h_o
);

  localparam int FB = FRAC_BITS;
  localparam int VW = FB + 1;                  // component after clamp, holds ONE
  localparam int DW = FB + 4;                  // holds 6*ONE doubled
  localparam int CW = (FB + 1 > FW) ? FB + 1 : FW;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FB;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FB;

  // Hue numerator cases, by which component is max and which is min
  localparam logic [2:0] HC_R_GMIN  = 3'd0;
  localparam logic [2:0] HC_R_OTHER = 3'd1;
  localparam logic [2:0] HC_G_BMIN  = 3'd2;
  localparam logic [2:0] HC_G_OTHER = 3'd3;
  localparam logic [2:0] HC_B_RMIN  = 3'd4;
  localparam logic [2:0] HC_B_OTHER = 3'd5;

  // Hexcone sectors
  localparam logic [2:0] SEC_0    = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_WRAP = 3'd6;

  function automatic logic [VW-1:0] clamp_one(input field_t x);
    logic [CW-1:0] xw;
    xw = CW'(x);
    return (xw > ONE_C) ? ONE_V : VW'(xw);
  endfunction

  // ---------------- stage 1: clamp ----------------
  logic          s1_valid_r;
  logic          s1_hsv_r;
  logic [VW-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_hsv_r <= in_req_type;
    s1_a_r   <= clamp_one(in_first);
    s1_b_r   <= clamp_one(in_second);
    s1_c_r   <= clamp_one(in_third);
  end

  // ---------------- stage 2: max/min, case select; hue sector ----------------
  logic [VW-1:0] mx_nxt, mn_nxt, t_nxt;
  logic [2:0]    hc_nxt;
  logic [DW-1:0] h6;
  logic [2:0]    sec_nxt;
  logic [FB-1:0] f_nxt;

  always_comb begin
    mx_nxt = (s1_a_r >= s1_b_r) ? ((s1_a_r >= s1_c_r) ? s1_a_r : s1_c_r)
                                : ((s1_b_r >= s1_c_r) ? s1_b_r : s1_c_r);
    mn_nxt = (s1_a_r <= s1_b_r) ? ((s1_a_r <= s1_c_r) ? s1_a_r : s1_c_r)
                                : ((s1_b_r <= s1_c_r) ? s1_b_r : s1_c_r);
    if (mx_nxt == s1_a_r) begin
      hc_nxt = (mn_nxt == s1_b_r) ? HC_R_GMIN : HC_R_OTHER;
    end else if (mx_nxt == s1_b_r) begin
      hc_nxt = (mn_nxt == s1_c_r) ? HC_G_BMIN : HC_G_OTHER;
    end else begin
      hc_nxt = (mn_nxt == s1_a_r) ? HC_B_RMIN : HC_B_OTHER;
    end
    case (hc_nxt)
      HC_R_GMIN:  t_nxt = mx_nxt - s1_c_r;
      HC_R_OTHER: t_nxt = mx_nxt - s1_b_r;
      HC_G_BMIN:  t_nxt = mx_nxt - s1_a_r;
      HC_G_OTHER: t_nxt = mx_nxt - s1_c_r;
      HC_B_RMIN:  t_nxt = mx_nxt - s1_b_r;
      default:    t_nxt = mx_nxt - s1_a_r;
    endcase
    // hue times six splits into sector and fraction
    h6      = (DW'(s1_a_r) << 2) + (DW'(s1_a_r) << 1);
    sec_nxt = h6[FB+2:FB];
    f_nxt   = h6[FB-1:0];
    if (sec_nxt >= SEC_WRAP) begin
      sec_nxt = SEC_0;
      f_nxt   = '0;
    end
  end

  logic          s2_valid_r, s2_hsv_r;
  logic [VW-1:0] s2_mx_r, s2_d_r, s2_t_r;
  logic [2:0]    s2_hc_r;
  logic [2:0]    s2_sec_r;
  logic [FB-1:0] s2_f_r;
  logic [VW-1:0] s2_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // value: the max for RGB to HSV, the third component for HSV to RGB
  always_ff @(posedge clk) begin
    s2_hsv_r <= s1_hsv_r;
    s2_mx_r  <= s1_hsv_r ? s1_c_r : mx_nxt;
    s2_d_r   <= mx_nxt - mn_nxt;
    s2_t_r   <= t_nxt;
    s2_hc_r  <= hc_nxt;
    s2_sec_r <= sec_nxt;
    s2_f_r   <= f_nxt;
    s2_s_r   <= s1_b_r;
  end

  // ---------------- stage 3: hue numerator; s*f products ----------------
  logic [DW-1:0]   dw_d, dw_t, num_nxt;
  logic [2*VW-1:0] sf_prod, sg_prod;
  logic [VW-1:0]   omf;

  always_comb begin
    dw_d = DW'(s2_d_r);
    dw_t = DW'(s2_t_r);
    case (s2_hc_r)
      HC_R_GMIN:  num_nxt = (dw_d << 2) + dw_d + dw_t;
      HC_R_OTHER: num_nxt = dw_d - dw_t;
      HC_G_BMIN:  num_nxt = dw_d + dw_t;
      HC_G_OTHER: num_nxt = (dw_d << 1) + dw_d - dw_t;
      HC_B_RMIN:  num_nxt = (dw_d << 1) + dw_d + dw_t;
      default:    num_nxt = (dw_d << 2) + dw_d - dw_t;
    endcase
    omf     = ONE_V - VW'(s2_f_r);
    sf_prod = (2*VW)'(s2_s_r) * (2*VW)'(s2_f_r);
    sg_prod = (2*VW)'(s2_s_r) * (2*VW)'(omf);
  end

  logic          s3_valid_r, s3_hsv_r;
  logic [VW-1:0] s3_mx_r, s3_d_r;
  logic [DW-1:0] s3_num_r, s3_d6_r;
  logic [2:0]    s3_sec_r;
  logic [VW-1:0] s3_sf_r, s3_sg_r, s3_os_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_hsv_r <= s2_hsv_r;
    s3_mx_r  <= s2_mx_r;
    s3_d_r   <= s2_d_r;
    s3_num_r <= num_nxt;
    s3_d6_r  <= (dw_d << 2) + (dw_d << 1);
    s3_sec_r <= s2_sec_r;
    s3_sf_r  <= VW'(sf_prod >> FB);
    s3_sg_r  <= VW'(sg_prod >> FB);
    s3_os_r  <= ONE_V - s2_s_r;
  end

  // ---------------- stage 4: p terms, sector pick; first quotient bit ----------------
  logic [2*VW-1:0] p1_prod, p2_prod, p3_prod;
  logic [VW-1:0]   p1, p2, p3, vv;
  logic [VW-1:0]   r_c, g_c, b_c;
  logic [DW-1:0]   sat_x, sat_y;
  logic            sat_bit, hue_bit;

  always_comb begin
    vv      = s3_mx_r;
    p1_prod = (2*VW)'(vv) * (2*VW)'(s3_os_r);
    p2_prod = (2*VW)'(vv) * (2*VW)'(ONE_V - s3_sf_r);
    p3_prod = (2*VW)'(vv) * (2*VW)'(ONE_V - s3_sg_r);
    p1      = VW'(p1_prod >> FB);
    p2      = VW'(p2_prod >> FB);
    p3      = VW'(p3_prod >> FB);
    case (s3_sec_r)
      SEC_0:   begin r_c = vv; g_c = p3; b_c = p1; end
      SEC_1:   begin r_c = p2; g_c = vv; b_c = p1; end
      SEC_2:   begin r_c = p1; g_c = vv; b_c = p3; end
      SEC_3:   begin r_c = p1; g_c = p2; b_c = vv; end
      SEC_4:   begin r_c = p3; g_c = p1; b_c = vv; end
      default: begin r_c = vv; g_c = p1; b_c = p2; end
    endcase
    sat_x   = DW'(s3_d_r);
    sat_y   = DW'(s3_mx_r);
    sat_bit = (sat_x >= sat_y);
    hue_bit = (s3_num_r >= s3_d6_r);
  end

  side_t side_nxt;

  always_comb begin
    side_nxt.valid    = s3_valid_r;
    side_nxt.hsv      = s3_hsv_r;
    side_nxt.sat_zero = (s3_mx_r == '0);
    side_nxt.hue_zero = (s3_d_r == '0);
    side_nxt.c0       = FW'(r_c);
    side_nxt.c1       = FW'(g_c);
    side_nxt.c2       = s3_hsv_r ? FW'(b_c) : FW'(s3_mx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o.valid <= 1'b0;
    end else begin
      side_o.valid <= side_nxt.valid;
    end
    side_o.hsv      <= side_nxt.hsv;
    side_o.sat_zero <= side_nxt.sat_zero;
    side_o.hue_zero <= side_nxt.hue_zero;
    side_o.c0       <= side_nxt.c0;
    side_o.c1       <= side_nxt.c1;
    side_o.c2       <= side_nxt.c2;
    rem_s_o         <= sat_bit ? sat_x - sat_y : sat_x;
    dvs_s_o         <= sat_y;
    quo_s_o         <= (FB+1)'(sat_bit);
    rem_h_o         <= hue_bit ? s3_num_r - s3_d6_r : s3_num_r;
    dvs_h_o         <= s3_d6_r;
    quo_h_o         <= (FB+1)'(hue_bit);
  end

endmodule

// ----- design/rhc_div_cell.sv -----
// One restoring-divide cell: a quotient bit for saturation and for hue per beat.
module rhc_div_cell
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  side_t                side_i,
  input  logic [FRAC_BITS+3:0] rem_s_i,
  input  logic [FRAC_BITS+3:0] dvs_s_i,
  input  logic [FRAC_BITS:0]   quo_s_i,
  input  logic [FRAC_BITS+3:0] rem_h_i,
  input  logic [FRAC_BITS+3:0] dvs_h_i,
  input  logic [FRAC_BITS:0]   quo_h_i,
  output side_t                side_o,
  output logic [FRAC_BITS+3:0] rem_s_o,
  output logic [FRAC_BITS+3:0] dvs_s_o,
  output logic [FRAC_BITS:0]   quo_s_o,
  output logic [FRAC_BITS+3:0] rem_h_o,
  output logic [FRAC_BITS+3:0] dvs_h_o,
  output logic [FRAC_BITS:0]   quo_h_o
);

  localparam int FB = FRAC_BITS;
  localparam int DW = FB + 4;

  // shift in the next (zero) numerator bit, trial subtract
  logic [DW-1:0] r2_s, r2_h;
  logic          bit_s, bit_h;

  always_comb begin
    r2_s  = rem_s_i << 1;
    r2_h  = rem_h_i << 1;
    bit_s = (r2_s >= dvs_s_i);
    bit_h = (r2_h >= dvs_h_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o.valid <= 1'b0;
    end else begin
      side_o.valid <= side_i.valid;
    end
    side_o.hsv      <= side_i.hsv;
    side_o.sat_zero <= side_i.sat_zero;
    side_o.hue_zero <= side_i.hue_zero;
    side_o.c0       <= side_i.c0;
    side_o.c1       <= side_i.c1;
    side_o.c2       <= side_i.c2;
    rem_s_o         <= bit_s ? r2_s - dvs_s_i : r2_s;
    dvs_s_o         <= dvs_s_i;
    quo_s_o         <= {quo_s_i[FB-1:0], bit_s};
    rem_h_o         <= bit_h ? r2_h - dvs_h_i : r2_h;
    dvs_h_o         <= dvs_h_i;
    quo_h_o         <= {quo_h_i[FB-1:0], bit_h};
  end

  // partial remainders stay below the divisor
  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    side_o.valid && !side_o.hsv && !side_o.sat_zero |-> rem_s_o < dvs_s_o)
    else $error("saturation remainder not below divisor");

  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    side_o.valid && !side_o.hsv && !side_o.hue_zero |-> rem_h_o < dvs_h_o)
    else $error("hue remainder not below divisor");

endmodule

// ----- design/rgb_hsv_color_convert.sv -----
// Top level: hexcone RGB/HSV converter, front pipeline plus a row of divide cells.
// A beat passes the front stages, then the divide cells, then the output register.
// Throughput: one beat per clock; busy is never raised, the pipeline has no stalls.
// The divide row has FRAC_BITS cells, one quotient bit per cell.
// Reset (synchronous, rst_n low) clears all valid flags; payload registers are not cleared.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
module rgb_hsv_color_convert
  import rhc_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  logic   in_req_type,
  input  field_t in_first,
  input  field_t in_second,
  input  field_t in_third,
  output logic   out_valid,
  output field_t out_first,
  output field_t out_second,
  output field_t out_third
);

  localparam int FB = FRAC_BITS;
  localparam int DW = FB + 4;

  side_t         side   [0:FB];
  logic [DW-1:0] rem_s  [0:FB];
  logic [DW-1:0] dvs_s  [0:FB];
  logic [FB:0]   quo_s  [0:FB];
  logic [DW-1:0] rem_h  [0:FB];
  logic [DW-1:0] dvs_h  [0:FB];
  logic [FB:0]   quo_h  [0:FB];

  assign busy = 1'b0;

  rhc_front #(.FRAC_BITS(FB)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start && !busy),
    .in_req_type (in_req_type),
    .in_first    (in_first),
    .in_second   (in_second),
    .in_third    (in_third),
    .side_o      (side[0]),
    .rem_s_o     (rem_s[0]),
    .dvs_s_o     (dvs_s[0]),
    .quo_s_o     (quo_s[0]),
    .rem_h_o     (rem_h[0]),
    .dvs_h_o     (dvs_h[0]),
    .quo_h_o     (quo_h[0])
  );

  // row of divide cells
  for (genvar k = 0; k < FB; k++) begin : g_cell
    rhc_div_cell #(.FRAC_BITS(FB)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .side_i  (side[k]),
      .rem_s_i (rem_s[k]),
      .dvs_s_i (dvs_s[k]),
      .quo_s_i (quo_s[k]),
      .rem_h_i (rem_h[k]),
      .dvs_h_i (dvs_h[k]),
      .quo_h_i (quo_h[k]),
      .side_o  (side[k+1]),
      .rem_s_o (rem_s[k+1]),
      .dvs_s_o (dvs_s[k+1]),
      .quo_s_o (quo_s[k+1]),
      .rem_h_o (rem_h[k+1]),
      .dvs_h_o (dvs_h[k+1]),
      .quo_h_o (quo_h[k+1])
    );
  end

  // output register: pick direction, apply forced-zero cases
  side_t  last;
  field_t first_nxt, second_nxt;
  logic   out_valid_r;
  field_t out_first_r, out_second_r, out_third_r;

  always_comb begin
    last = side[FB];
    if (last.hsv) begin
      first_nxt  = last.c0;
      second_nxt = last.c1;
    end else begin
      first_nxt  = last.hue_zero ? '0 : FW'(quo_h[FB]);
      second_nxt = last.sat_zero ? '0 : FW'(quo_s[FB]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_first_r  <= first_nxt;
    out_second_r <= second_nxt;
    out_third_r  <= last.c2;
  end

  assign out_valid  = out_valid_r;
  assign out_first  = out_first_r;
  assign out_second = out_second_r;
  assign out_third  = out_third_r;

  // a black pixel must come out with zero value
  a_black_value: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid && !last.hsv && last.sat_zero |=> out_valid && out_third == '0)
    else $error("zero max did not give zero value");

endmodule
